@@ src/variant_path_parser_defines.svh @@
// Assertion macros shared by the parser files.
`ifndef VARIANT_PATH_PARSER_DEFINES_SVH
`define VARIANT_PATH_PARSER_DEFINES_SVH

// Check a property on every clock outside of reset.
`define VPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define VPP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ src/vpp_pkg.sv @@
`default_nettype none

package vpp_pkg;

   // Result word kinds
   typedef enum logic [2:0] {
      KIND_KEY_BYTE = 3'd0,
      KIND_KEY_END  = 3'd1,
      KIND_INDEX    = 3'd2,
      KIND_ACCEPT   = 3'd3,
      KIND_REJECT   = 3'd4
   } rec_kind_type;

   // Characters of the path syntax
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_OPEN    = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE   = 8'h5D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam int unsigned INDEX_W = 31;
   localparam logic [INDEX_W-1:0] INDEX_MAX = 31'h7FFF_FFFF;

   // Most result words one input word can cause
   localparam int unsigned PUSH_MAX = 3;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      rec_kind_type        kind;
      logic [7:0]          key_byte;
      logic [INDEX_W-1:0]  index_value;
      logic                run_end;
   } rec_type;

   // Result words handed from the parser to the queue in the same cycle
   typedef struct packed {
      logic [1:0]                 count;
      rec_type [PUSH_MAX-1:0]     recs;
   } push_type;

endpackage

`default_nettype wire

@@ src/vpp_parser.sv @@
`default_nettype none

module vpp_parser (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     path_byte,
   input  wire logic           no_byte,
   input  wire logic           last_byte,
   output vpp_pkg::push_type   push
);
   import vpp_pkg::*;

   `include "variant_path_parser_defines.svh"

   typedef enum logic [3:0] {
      MODE_SEEK      = 4'd0,
      MODE_SEG       = 4'd1,
      MODE_DOT_FIRST = 4'd2,
      MODE_DOT_BODY  = 4'd3,
      MODE_BRACKET   = 4'd4,
      MODE_INDEX     = 4'd5,
      MODE_Q_FIRST   = 4'd6,
      MODE_Q_BODY    = 4'd7,
      MODE_Q_CLOSE   = 4'd8,
      MODE_ERROR     = 4'd9
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [INDEX_W-1:0]   accum_ff, accum_in;
   logic                 qdbl_ff, qdbl_in;

   // Per-byte outcome before the end-of-path handling
   mode_type             mid_mode;
   logic [INDEX_W-1:0]   mid_accum;
   logic                 mid_qdbl;
   logic                 take_valid;
   rec_type              take_rec;

   logic [7:0]           quote_char;
   logic                 is_digit;
   logic [3:0]           digit;
   logic [INDEX_W+3:0]   accum_next;
   logic                 overflow;

   rec_type              cand [PUSH_MAX];
   logic [PUSH_MAX-1:0]  cand_valid;
   rec_type [PUSH_MAX-1:0] recs;
   logic [1:0]           num;
   logic [1:0]           last_slot;

   assign quote_char = qdbl_ff ? CHAR_DQUOTE : CHAR_SQUOTE;
   assign is_digit   = (path_byte >= CHAR_ZERO) && (path_byte <= CHAR_NINE);
   assign digit      = 4'(path_byte - CHAR_ZERO);

   // Index times ten plus the new digit, with room to see overflow
   assign accum_next = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                     + (INDEX_W+4)'(digit);
   assign overflow   = accum_next > (INDEX_W+4)'(INDEX_MAX);

   // Decode one path byte
   always_comb begin
      mid_mode   = mode_ff;
      mid_accum  = accum_ff;
      mid_qdbl   = qdbl_ff;
      take_valid = 1'b0;
      take_rec   = '{kind: KIND_KEY_BYTE, key_byte: path_byte, index_value: '0, run_end: 1'b0};
      case (mode_ff)
         MODE_SEEK: begin
            if (path_byte == CHAR_DOLLAR) mid_mode = MODE_SEG;
         end
         MODE_SEG: begin
            if (path_byte == CHAR_DOT) mid_mode = MODE_DOT_FIRST;
            else if (path_byte == CHAR_OPEN) mid_mode = MODE_BRACKET;
            else mid_mode = MODE_ERROR;
         end
         MODE_DOT_FIRST: begin
            if (path_byte == CHAR_DOT || path_byte == CHAR_OPEN) begin
               mid_mode = MODE_ERROR;
            end else begin
               take_valid = 1'b1;
               mid_mode   = MODE_DOT_BODY;
            end
         end
         MODE_DOT_BODY: begin
            take_valid = 1'b1;
            if (path_byte == CHAR_DOT) begin
               take_rec.kind     = KIND_KEY_END;
               take_rec.key_byte = '0;
               mid_mode          = MODE_DOT_FIRST;
            end else if (path_byte == CHAR_OPEN) begin
               take_rec.kind     = KIND_KEY_END;
               take_rec.key_byte = '0;
               mid_mode          = MODE_BRACKET;
            end
         end
         MODE_BRACKET: begin
            if (is_digit) begin
               mid_accum = INDEX_W'(digit);
               mid_mode  = MODE_INDEX;
            end else if (path_byte == CHAR_SQUOTE || path_byte == CHAR_DQUOTE) begin
               mid_qdbl = (path_byte == CHAR_DQUOTE);
               mid_mode = MODE_Q_FIRST;
            end else begin
               mid_mode = MODE_ERROR;
            end
         end
         MODE_INDEX: begin
            if (is_digit) begin
               if (overflow) mid_mode = MODE_ERROR;
               else mid_accum = accum_next[INDEX_W-1:0];
            end else if (path_byte == CHAR_CLOSE) begin
               take_valid           = 1'b1;
               take_rec.kind        = KIND_INDEX;
               take_rec.key_byte    = '0;
               take_rec.index_value = accum_ff;
               mid_accum            = '0;
               mid_mode             = MODE_SEG;
            end else begin
               mid_mode = MODE_ERROR;
            end
         end
         MODE_Q_FIRST: begin
            if (path_byte == quote_char) begin
               mid_mode = MODE_ERROR;
            end else begin
               take_valid = 1'b1;
               mid_mode   = MODE_Q_BODY;
            end
         end
         MODE_Q_BODY: begin
            if (path_byte == quote_char) mid_mode = MODE_Q_CLOSE;
            else take_valid = 1'b1;
         end
         MODE_Q_CLOSE: begin
            if (path_byte == CHAR_CLOSE) begin
               take_valid        = 1'b1;
               take_rec.kind     = KIND_KEY_END;
               take_rec.key_byte = '0;
               mid_mode          = MODE_SEG;
            end else begin
               mid_mode = MODE_ERROR;
            end
         end
         default: begin
            mid_mode = MODE_ERROR;
         end
      endcase
   end

   // Line up the candidate words: byte word, closing key end, final verdict
   always_comb begin
      cand[0] = take_rec;
      cand[1] = '{kind: KIND_KEY_END, key_byte: '0, index_value: '0, run_end: 1'b0};
      cand[2] = '{kind: KIND_REJECT, key_byte: '0, index_value: '0, run_end: 1'b0};
      cand_valid = '0;
      if (no_byte) begin
         cand_valid[2] = 1'b1;
      end else begin
         cand_valid[0] = take_valid;
         if (last_byte) begin
            cand_valid[2] = 1'b1;
            if (mid_mode == MODE_SEG) begin
               cand[2].kind = KIND_ACCEPT;
            end else if (mid_mode == MODE_DOT_BODY) begin
               cand_valid[1] = 1'b1;
               cand[2].kind  = KIND_ACCEPT;
            end
         end
      end
   end

   // Pack the valid words in order and flag the last one
   always_comb begin
      recs = '0;
      num  = 2'd0;
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (cand_valid[i]) begin
            recs[num] = cand[i];
            num       = num + 2'd1;
         end
      end
      last_slot = num - 2'd1;
      if (num != 2'd0) recs[last_slot].run_end = 1'b1;
      push.count = accept ? num : 2'd0;
      push.recs  = recs;
   end

   // Advance the parse state; an end of path drops back to reset values
   always_comb begin
      mode_in  = mode_ff;
      accum_in = accum_ff;
      qdbl_in  = qdbl_ff;
      if (accept) begin
         if (no_byte || last_byte) begin
            mode_in  = MODE_SEEK;
            accum_in = '0;
            qdbl_in  = 1'b0;
         end else begin
            mode_in  = mid_mode;
            accum_in = mid_accum;
            qdbl_in  = mid_qdbl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SEEK;
         accum_ff <= '0;
         qdbl_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         qdbl_ff  <= qdbl_in;
      end
   end

   `VPP_ASSERT(a_seek_accum_clear, (mode_ff == MODE_SEEK) |-> (accum_ff == '0), "index left over while seeking root")
   `VPP_ASSERT_NEXT(a_end_resets, accept && (no_byte || last_byte), mode_ff == MODE_SEEK, "path end did not reset the parser")
   `VPP_ASSERT(a_three_only_at_end, (push.count == 2'd3) |-> (accept && last_byte && !no_byte), "three words from a byte that does not end the path")

endmodule

`default_nettype wire

@@ src/vpp_result_queue.sv @@
`default_nettype none

module vpp_result_queue #(
   parameter int unsigned DEPTH = vpp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire vpp_pkg::push_type push,
   output logic                space_ok,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output vpp_pkg::rec_type    rsp_rec
);
   import vpp_pkg::*;

   `include "variant_path_parser_defines.svh"

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rec_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_rec   = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   // Take a new input word only when a full burst of results fits
   assign space_ok  = (count_ff <= CNT_W'(DEPTH - PUSH_MAX));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   // Store the incoming words
   always_ff @(posedge clock) begin
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (i < int'(push.count)) mem_ff[wr_ptr_ff + PTR_W'(i)] <= push.recs[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `VPP_ASSERT(a_no_overflow,
      (push.count != 2'd0) |-> ((count_ff + push.count) <= DEPTH),
      "result queue overflow")
   `VPP_ASSERT_NEXT(a_pop_only, pop && (push.count == 2'd0),
      count_ff == $past(count_ff) - 1'b1, "count did not drop on a pop")
   `VPP_ASSERT_NEXT(a_head_hold, rsp_valid && !rsp_ready, $stable(rd_ptr_ff),
      "queue head moved while stalled")

endmodule

`default_nettype wire

@@ src/variant_path_parser.sv @@
// Streaming path parser. The req channel takes one path character per word
// (req_path_byte) with req_last_byte on the final character, or a single word
// with req_no_byte set for an empty path. The rsp channel returns result words:
// key bytes, key ends, whole array indices, and one accept or reject verdict
// per path; rsp_run_end marks the last word caused by an input word.
// Each accepted word's results are offered on rsp from the queue. A word causes
// zero to three result words, and rsp carries one per cycle while rsp_ready is
// high, so the rsp port sets the pace: one input word per cycle while each word
// yields at most one result and the receiver keeps up, longer when a word
// yields two or three. Results wait in a queue of QUEUE_DEPTH words; req_ready
// is high while it holds QUEUE_DEPTH-3 words or fewer, so a stalled receiver
// lets the queue fill and then holds off the req side without losing words.
// Reset clears the parser to the seek-root state and empties the queue.
`default_nettype none

module variant_path_parser #(
   parameter int unsigned QUEUE_DEPTH = vpp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_path_byte,
   input  wire logic         req_no_byte,
   input  wire logic         req_last_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_rec_kind,
   output logic [7:0]        rsp_key_byte,
   output logic [30:0]       rsp_index_value,
   output logic              rsp_run_end
);
   import vpp_pkg::*;

   push_type   push;
   rec_type    head;
   logic       accept;

   assign accept = req_valid && req_ready;

   // Decode each accepted word into its results
   vpp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .path_byte (req_path_byte),
      .no_byte   (req_no_byte),
      .last_byte (req_last_byte),
      .push      (push)
   );

   // Hold results until the receiver takes them
   vpp_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_rec   (head)
   );

   assign rsp_rec_kind    = head.kind;
   assign rsp_key_byte    = head.key_byte;
   assign rsp_index_value = head.index_value;
   assign rsp_run_end     = head.run_end;

endmodule

`default_nettype wire
